/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on the rising clock edge outside reset
`define BPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication
`define BPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `BPQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define BPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `BPQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* design/bpq_pkg.sv */
// Package for the button press qualifier queue: types, field layout, constants.
// No dependencies; used by every module of the block by scoped names.
package bpq_pkg;

    // Key and code sizes, fixed by the field widths of the stream
    localparam int NUM_KEYS      = 4;
    localparam int KEY_IDX_W     = 2;
    localparam int EVENT_W       = 4;
    localparam int TICK_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int DEBOUNCE_W    = 16;
    localparam int OP_W          = 2;

    // Defaults
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd40;
    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int CMD_DEPTH       = 2;

    // Slave tdata layout: button, level, initial_levels, now_ms
    localparam int S_BUTTON_LSB = 0;
    localparam int S_LEVEL_LSB  = S_BUTTON_LSB + KEY_IDX_W;
    localparam int S_LEVELS_LSB = S_LEVEL_LSB + 1;
    localparam int S_NOW_LSB    = S_LEVELS_LSB + NUM_KEYS;
    localparam int S_DATA_BITS  = S_NOW_LSB + TICK_W;
    localparam int S_TDATA_W    = ((S_DATA_BITS + 7) / 8) * 8;

    // Master tdata layout: event_bits, edge_count, dropped_count
    localparam int M_EVENT_LSB  = 0;
    localparam int M_EDGE_LSB   = M_EVENT_LSB + EVENT_W;
    localparam int M_DROP_LSB   = M_EDGE_LSB + COUNT_W;
    localparam int M_DATA_BITS  = M_DROP_LSB + COUNT_W;
    localparam int M_TDATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic REG_DEBOUNCE = 1'b0;

    // Item kinds
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_EDGE  = 2'd1,
        OP_POP   = 2'd2,
        OP_STATS = 2'd3
    } t_op;

    // Classified item as held in the command queue
    typedef struct packed {
        t_op                 op;
        logic [KEY_IDX_W-1:0] key;
        logic [NUM_KEYS-1:0]  key_bit;
        logic                 level;
        logic [NUM_KEYS-1:0]  levels;
        logic [TICK_W-1:0]    now;
        logic [TICK_W-1:0]    start_accept;
    } t_cmd;

    // Command queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* design/bpq_front.sv */
// Front end: takes input transactions and classifies them into queue commands.
// Depends on bpq_pkg.
module bpq_front (
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bpq_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic [bpq_pkg::OP_W-1:0]          i_s_tuser,
    input  logic [bpq_pkg::DEBOUNCE_W-1:0]    i_debounce,
    input  bpq_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output bpq_pkg::t_cmd                     o_cmd
);

    logic [bpq_pkg::KEY_IDX_W-1:0] w_key;
    logic [bpq_pkg::TICK_W-1:0]    w_now;

    // Take a transaction whenever the queue has room
    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && !i_q_stat.full;

    assign w_key = i_s_tdata[bpq_pkg::S_BUTTON_LSB +: bpq_pkg::KEY_IDX_W];
    assign w_now = i_s_tdata[bpq_pkg::S_NOW_LSB +: bpq_pkg::TICK_W];

    // Unpack and pre-compute the key mask and the start accept time
    always_comb begin
        o_cmd.op           = bpq_pkg::t_op'(i_s_tuser);
        o_cmd.key          = w_key;
        o_cmd.key_bit      = bpq_pkg::NUM_KEYS'(1) << w_key;
        o_cmd.level        = i_s_tdata[bpq_pkg::S_LEVEL_LSB];
        o_cmd.levels       = i_s_tdata[bpq_pkg::S_LEVELS_LSB +: bpq_pkg::NUM_KEYS];
        o_cmd.now          = w_now;
        o_cmd.start_accept = w_now - bpq_pkg::TICK_W'(i_debounce);
    end

endmodule

/* design/bpq_cmd_fifo.sv */
// Short command queue between the front and back ends.
// Depends on bpq_pkg for the command type and depth.
module bpq_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bpq_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output bpq_pkg::t_cmd    o_cmd,
    output bpq_pkg::t_q_stat o_stat
);

    localparam int DEPTH = bpq_pkg::CMD_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpq_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* design/bpq_back.sv */
// Back end: key state, qualification, event ring, counters and the result register.
// Depends on bpq_pkg.
module bpq_back #(
    parameter int QUEUE_SLOTS = bpq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bpq_pkg::DEBOUNCE_W-1:0]    i_debounce,
    input  bpq_pkg::t_q_stat                  i_q_stat,
    input  bpq_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bpq_pkg::EVENT_W-1:0]       o_event_bits,
    output logic [bpq_pkg::COUNT_W-1:0]       o_edge_count,
    output logic [bpq_pkg::COUNT_W-1:0]       o_dropped_count
);

    localparam int QPW = $clog2(QUEUE_SLOTS);
    localparam int NK  = bpq_pkg::NUM_KEYS;
    localparam int TW  = bpq_pkg::TICK_W;
    localparam int CW  = bpq_pkg::COUNT_W;

    // Key state
    logic [NK-1:0] r_down, n_down;
    logic [NK-1:0] r_blocked, n_blocked;
    logic          r_started, n_started;
    logic [TW-1:0] r_press [NK];
    logic [TW-1:0] n_press [NK];
    logic [TW-1:0] r_accept [NK];
    logic [TW-1:0] n_accept [NK];
    logic [CW-1:0] r_edges [NK];
    logic [CW-1:0] n_edges [NK];
    logic [CW-1:0] r_lost, n_lost;

    // Event ring
    logic [bpq_pkg::EVENT_W-1:0] r_ring [QUEUE_SLOTS];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPW-1:0] w_wr_next, w_rd_next;
    logic           w_ring_we;
    logic           w_ring_re;
    logic [bpq_pkg::EVENT_W-1:0] r_rd_data;

    // Result register
    logic          r_out_valid;
    logic          r_pop_hit, n_pop_hit;
    logic [CW-1:0] r_edge_cnt, n_edge_cnt;
    logic [CW-1:0] r_drop_cnt, n_drop_cnt;

    logic          w_fire;
    logic [TW-1:0] w_deb;

    // One command per cycle while the result slot is free or draining
    assign w_fire = !i_q_stat.empty && (!r_out_valid || i_m_tready);
    assign o_pop  = w_fire;
    assign w_deb  = TW'(i_debounce);

    assign w_wr_next = (r_wr_ptr == QPW'(QUEUE_SLOTS - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == QPW'(QUEUE_SLOTS - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Command execution
    always_comb begin
        logic [NK-1:0] v_down;
        logic          v_qual;
        n_down     = r_down;
        n_blocked  = r_blocked;
        n_started  = r_started;
        n_press    = r_press;
        n_accept   = r_accept;
        n_edges    = r_edges;
        n_lost     = r_lost;
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        w_ring_we  = 1'b0;
        w_ring_re  = 1'b0;
        n_pop_hit  = 1'b0;
        n_edge_cnt = '0;
        n_drop_cnt = '0;
        v_down     = r_down | i_cmd.key_bit;
        v_qual     = 1'b0;
        if (w_fire) begin
            unique case (i_cmd.op)
                bpq_pkg::OP_START: begin
                    n_down    = i_cmd.levels;
                    n_blocked = i_cmd.levels;
                    n_wr_ptr  = '0;
                    n_rd_ptr  = '0;
                    n_lost    = '0;
                    n_started = 1'b1;
                    for (int k = 0; k < NK; k++) begin
                        n_edges[k]  = '0;
                        n_press[k]  = i_cmd.now;
                        n_accept[k] = i_cmd.start_accept;
                    end
                end
                bpq_pkg::OP_EDGE: begin
                    if (r_started) begin
                        n_edges[i_cmd.key] = r_edges[i_cmd.key] + 1'b1;
                        if (!i_cmd.level) begin
                            // press: note the time, block on chords
                            if (!r_down[i_cmd.key]) begin
                                n_press[i_cmd.key] = i_cmd.now;
                            end
                            n_down = v_down;
                            if ((v_down & (v_down - 1'b1)) != '0) begin
                                n_blocked = r_blocked | v_down;
                            end
                        end else begin
                            // release: qualify the press
                            v_qual = r_down[i_cmd.key] && !r_blocked[i_cmd.key] &&
                                     ((i_cmd.now - r_press[i_cmd.key]) >= w_deb) &&
                                     ((i_cmd.now - r_accept[i_cmd.key]) >= w_deb);
                            if (v_qual) begin
                                if (w_wr_next == r_rd_ptr) begin
                                    n_lost = r_lost + 1'b1;
                                end else begin
                                    w_ring_we = 1'b1;
                                    n_wr_ptr  = w_wr_next;
                                end
                                n_accept[i_cmd.key] = i_cmd.now;
                            end
                            n_down    = r_down & ~i_cmd.key_bit;
                            n_blocked = r_blocked & ~i_cmd.key_bit;
                        end
                    end
                end
                bpq_pkg::OP_POP: begin
                    if (r_rd_ptr != r_wr_ptr) begin
                        w_ring_re = 1'b1;
                        n_pop_hit = 1'b1;
                        n_rd_ptr  = w_rd_next;
                    end
                end
                bpq_pkg::OP_STATS: begin
                    n_edge_cnt = r_edges[i_cmd.key];
                    n_drop_cnt = r_lost;
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down      <= '0;
            r_blocked   <= '0;
            r_started   <= 1'b0;
            r_lost      <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NK; k++) begin
                r_press[k]  <= '0;
                r_accept[k] <= '0;
                r_edges[k]  <= '0;
            end
        end else begin
            r_down    <= n_down;
            r_blocked <= n_blocked;
            r_started <= n_started;
            r_lost    <= n_lost;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_press   <= n_press;
            r_accept  <= n_accept;
            r_edges   <= n_edges;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, held while the transaction waits
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pop_hit  <= n_pop_hit;
            r_edge_cnt <= n_edge_cnt;
            r_drop_cnt <= n_drop_cnt;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_wr_ptr] <= bpq_pkg::EVENT_W'(i_cmd.key_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_re) begin
            r_rd_data <= r_ring[r_rd_ptr];
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_event_bits    = r_pop_hit ? r_rd_data : '0;
    assign o_edge_count    = r_edge_cnt;
    assign o_dropped_count = r_drop_cnt;

endmodule

/* design/button_press_qualifier_queue_core.sv */
// Top level of the button press qualifier queue: APB register, front end,
// command queue and back end. Depends on bpq_pkg, bpq_front, bpq_cmd_fifo,
// bpq_back and assert_macros.svh.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  s stream  | in        | i_s_tvalid / o_s_tready   | tuser operation, tdata key fields
//  m stream  | out       | o_m_tvalid / i_m_tready   | tdata event_bits, counts
//  apb       | in        | i_psel, i_penable, pready | debounce_ms at address 0
//
// One transaction per cycle sustained while the output is not stalled; an accepted
// input is written into the command queue, then executed into the result register.
// Ring reads are registered by the separate read port of the event memory.
// Synchronous active-low reset; no clearing pass, the ring is valid by its pointers.
// A stalled output fills the two-entry command queue before o_s_tready drops.
`include "assert_macros.svh"

module button_press_qualifier_queue_core #(
    parameter int QUEUE_SLOTS = bpq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] button, [2] level, [6:3] initial_levels, [38:7] now_ms, rest zero
    input  logic [bpq_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  logic [bpq_pkg::OP_W-1:0]          i_s_tuser,
    // stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] event_bits, [35:4] edge_count, [67:36] dropped_count, rest zero
    output logic [bpq_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // configuration
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [bpq_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [bpq_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [bpq_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);

    logic [bpq_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic                           w_reg_sel;

    bpq_pkg::t_cmd    w_front_cmd;
    bpq_pkg::t_cmd    w_back_cmd;
    bpq_pkg::t_q_stat w_q_stat;
    logic             w_push;
    logic             w_pop;

    logic [bpq_pkg::EVENT_W-1:0] w_event_bits;
    logic [bpq_pkg::COUNT_W-1:0] w_edge_count;
    logic [bpq_pkg::COUNT_W-1:0] w_dropped_count;

    // Register file: debounce time only
    assign o_pready  = 1'b1;
    assign w_reg_sel = (i_paddr[bpq_pkg::APB_ADDR_W-1] == bpq_pkg::REG_DEBOUNCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bpq_pkg::DEBOUNCE_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_reg_sel) begin
            r_debounce <= i_pwdata[bpq_pkg::DEBOUNCE_W-1:0];
        end
    end

    assign o_prdata = w_reg_sel ? bpq_pkg::APB_DATA_W'(r_debounce) : '0;

    // Front end
    bpq_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_debounce (r_debounce),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    // Command queue
    bpq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_stat  (w_q_stat)
    );

    // Back end
    bpq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_debounce      (r_debounce),
        .i_q_stat        (w_q_stat),
        .i_cmd           (w_back_cmd),
        .o_pop           (w_pop),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_event_bits    (w_event_bits),
        .o_edge_count    (w_edge_count),
        .o_dropped_count (w_dropped_count)
    );

    // Result packing
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[bpq_pkg::M_EVENT_LSB +: bpq_pkg::EVENT_W] = w_event_bits;
        o_m_tdata[bpq_pkg::M_EDGE_LSB +: bpq_pkg::COUNT_W]  = w_edge_count;
        o_m_tdata[bpq_pkg::M_DROP_LSB +: bpq_pkg::COUNT_W]  = w_dropped_count;
    end

    // Checks
    `BPQ_ASSERT_IMPL(a_queue_no_overflow, i_clk, i_rst_n, w_push, !w_q_stat.full, "overflow")
    `BPQ_ASSERT_IMPL(a_queue_no_underflow, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "underflow")
    `BPQ_ASSERT_NEXT(a_result_follows_exec, i_clk, i_rst_n, w_pop, o_m_tvalid, "no result")
    `BPQ_ASSERT_IMPL(a_event_onehot, i_clk, i_rst_n, o_m_tvalid, $onehot0(w_event_bits), "bad code")

endmodule

/* verif/bpq_scoreboard.sv */
// Scoreboard for the button press qualifier queue: snoops the input stream, the
// APB port and the result stream, predicts each result and compares field by field.
// Depends on bpq_pkg only.
`timescale 1ns / 100ps

module bpq_scoreboard #(
    parameter logic [bpq_pkg::APB_ADDR_W-1:0] DEBOUNCE_ADDR = '0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [bpq_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [bpq_pkg::OP_W-1:0]       i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [bpq_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [bpq_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [bpq_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [bpq_pkg::APB_DATA_W-1:0] i_prdata,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    import bpq_pkg::*;

    localparam int RING_SLOTS = QUEUE_SLOTS_DEF;
    localparam int RING_PTR_W = $clog2(RING_SLOTS);

    typedef struct packed {
        logic [EVENT_W-1:0] event_bits;
        logic [COUNT_W-1:0] edge_count;
        logic [COUNT_W-1:0] dropped_count;
    } t_outcome;

    // Predictor state
    logic [DEBOUNCE_W-1:0] debounce_q;
    logic [NUM_KEYS-1:0]   held_keys;
    logic [NUM_KEYS-1:0]   blocked_keys;
    logic                  armed;
    logic [TICK_W-1:0]     press_tick [NUM_KEYS];
    logic [TICK_W-1:0]     accept_tick [NUM_KEYS];
    logic [COUNT_W-1:0]    edge_tally [NUM_KEYS];
    logic [COUNT_W-1:0]    drop_tally;
    logic [EVENT_W-1:0]    press_ring [RING_SLOTS];
    logic [RING_PTR_W-1:0] ring_wr;
    logic [RING_PTR_W-1:0] ring_rd;

    t_outcome expected_results[$];
    int       fail_count = 0;
    int       waiting = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = waiting;

    // Input transaction fields
    logic [KEY_IDX_W-1:0] in_key;
    logic                 in_level;
    logic [NUM_KEYS-1:0]  in_levels;
    logic [TICK_W-1:0]    in_now;
    assign in_key    = i_s_tdata[S_BUTTON_LSB +: KEY_IDX_W];
    assign in_level  = i_s_tdata[S_LEVEL_LSB];
    assign in_levels = i_s_tdata[S_LEVELS_LSB +: NUM_KEYS];
    assign in_now    = i_s_tdata[S_NOW_LSB +: TICK_W];

    // Result transaction fields
    logic [EVENT_W-1:0] out_event;
    logic [COUNT_W-1:0] out_edges;
    logic [COUNT_W-1:0] out_drops;
    assign out_event = i_m_tdata[M_EVENT_LSB +: EVENT_W];
    assign out_edges = i_m_tdata[M_EDGE_LSB +: COUNT_W];
    assign out_drops = i_m_tdata[M_DROP_LSB +: COUNT_W];

    // Advance the key qualifier by one item and return the result it gives
    function automatic t_outcome qualify_item(t_op op, logic [KEY_IDX_W-1:0] key,
                                              logic level, logic [NUM_KEYS-1:0] levels,
                                              logic [TICK_W-1:0] now);
        t_outcome              res;
        logic [NUM_KEYS-1:0]   key_bit;
        logic [RING_PTR_W-1:0] next_wr;
        logic [TICK_W-1:0]     span;
        res = '0;
        key_bit = NUM_KEYS'(1) << key;
        span = TICK_W'(debounce_q);
        case (op)
            OP_START: begin
                // keys already held at start stay locked out until released
                held_keys    = levels;
                blocked_keys = levels;
                ring_wr      = '0;
                ring_rd      = '0;
                drop_tally   = '0;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    edge_tally[k]  = '0;
                    press_tick[k]  = now;
                    accept_tick[k] = now - span;
                end
                armed = 1'b1;
            end
            OP_EDGE: if (armed) begin
                edge_tally[key] = edge_tally[key] + 1'b1;
                if (!level) begin
                    // a repeated falling edge keeps the original press time
                    if ((held_keys & key_bit) == '0)
                        press_tick[key] = now;
                    held_keys = held_keys | key_bit;
                    if ((held_keys & (held_keys - 1'b1)) != '0)
                        blocked_keys = blocked_keys | held_keys;
                end else begin
                    if ((held_keys & key_bit) != '0 && (blocked_keys & key_bit) == '0 &&
                        (now - press_tick[key]) >= span &&
                        (now - accept_tick[key]) >= span) begin
                        next_wr = ring_wr + 1'b1;
                        if (next_wr == ring_rd) begin
                            drop_tally = drop_tally + 1'b1;
                        end else begin
                            press_ring[ring_wr] = key_bit;
                            ring_wr = next_wr;
                        end
                        accept_tick[key] = now;
                    end
                    held_keys    = held_keys & ~key_bit;
                    blocked_keys = blocked_keys & ~key_bit;
                end
            end
            OP_POP: if (ring_rd != ring_wr) begin
                res.event_bits = press_ring[ring_rd];
                ring_rd = ring_rd + 1'b1;
            end
            default: begin
                res.edge_count    = edge_tally[key];
                res.dropped_count = drop_tally;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            debounce_q   = DEBOUNCE_RESET;
            held_keys    = '0;
            blocked_keys = '0;
            armed        = 1'b0;
            drop_tally   = '0;
            ring_wr      = '0;
            ring_rd      = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_tick[k]  = '0;
                accept_tick[k] = '0;
                edge_tally[k]  = '0;
            end
            for (int s = 0; s < RING_SLOTS; s++)
                press_ring[s] = '0;
            expected_results.delete();
        end else begin
            // accepted input transaction: predict its result
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(qualify_item(t_op'(i_s_tuser), in_key, in_level,
                                                        in_levels, in_now));

            // accepted result transaction: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_bits", COUNT_W'(want.event_bits), COUNT_W'(out_event));
                    check_field("edge_count", want.edge_count, out_edges);
                    check_field("dropped_count", want.dropped_count, out_drops);
                end
            end

            // register access on the APB port
            if (i_psel && i_penable && i_pready && i_paddr == DEBOUNCE_ADDR) begin
                if (i_pwrite) begin
                    debounce_q = i_pwdata[DEBOUNCE_W-1:0];
                end else if (i_prdata !== APB_DATA_W'(debounce_q)) begin
                    $display("%0t: debounce_ms read mismatch, expected %0h, actual %0h",
                             $time, debounce_q, i_prdata);
                    fail_count++;
                end
            end
        end
        waiting = expected_results.size();
    end

endmodule

/* verif/testbench.sv */
// Top of the button press qualifier queue testbench: clock, reset, stimulus on the
// stream and APB ports, result-side back-pressure and the verdict.
// Depends on bpq_pkg, bpq_scoreboard and button_press_qualifier_queue_core.
`timescale 1ns / 100ps

module testbench;
    import bpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int LONG_HOLD   = 60;
    localparam logic [APB_ADDR_W-1:0] DEBOUNCE_ADDR = APB_ADDR_W'(4 * REG_DEBOUNCE);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [OP_W-1:0]       i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_psel     = 1'b0;
    logic                  i_penable  = 1'b0;
    logic                  i_pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] i_paddr    = '0;
    logic [APB_DATA_W-1:0] i_pwdata   = '0;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    int                fail_count;
    int                outstanding;
    int                sent_items  = 0;
    int                cycle_count = 0;
    int                cur_db      = DEBOUNCE_RESET;
    logic [TICK_W-1:0] tick        = '0;
    bit                tx_calm     = 1'b0;
    bit                rx_calm     = 1'b0;
    bit                rx_hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    button_press_qualifier_queue_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    bpq_scoreboard #(.DEBOUNCE_ADDR(DEBOUNCE_ADDR)) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_pready      (o_pready),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .i_prdata      (o_prdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // One input transaction, after a random gap unless the sender is in a calm stretch
    task automatic push_word(input t_op op, input logic [KEY_IDX_W-1:0] key,
                             input logic level, input logic [NUM_KEYS-1:0] levels,
                             input logic [TICK_W-1:0] now);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        word = '0;
        word[S_BUTTON_LSB +: KEY_IDX_W] = key;
        word[S_LEVEL_LSB]               = level;
        word[S_LEVELS_LSB +: NUM_KEYS]  = levels;
        word[S_NOW_LSB +: TICK_W]       = now;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
    endtask

    task automatic start_item(input logic [NUM_KEYS-1:0] levels, input logic [TICK_W-1:0] now);
        push_word(OP_START, KEY_IDX_W'($urandom()), 1'($urandom()), levels, now);
    endtask

    task automatic edge_item(input logic [KEY_IDX_W-1:0] key, input logic level,
                             input logic [TICK_W-1:0] now);
        push_word(OP_EDGE, key, level, NUM_KEYS'($urandom()), now);
    endtask

    task automatic pop_item();
        push_word(OP_POP, KEY_IDX_W'($urandom()), 1'($urandom()), NUM_KEYS'($urandom()),
                  $urandom());
    endtask

    task automatic stats_item(input logic [KEY_IDX_W-1:0] key);
        push_word(OP_STATS, key, 1'($urandom()), NUM_KEYS'($urandom()), $urandom());
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // APB write of debounce_ms, then a read back
    task automatic program_debounce(input logic [DEBOUNCE_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[DEBOUNCE_W-1:0] = value;
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= DEBOUNCE_ADDR;
        i_pwdata  <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        cur_db = value;
    endtask

    // Press length near the debounce threshold: one short, exact or longer
    function automatic int press_span();
        int span;
        case ($urandom_range(0, 3))
            0:       span = (cur_db > 0) ? cur_db - 1 : 0;
            1:       span = cur_db;
            default: span = cur_db + $urandom_range(0, 60);
        endcase
        return span;
    endfunction

    // Mostly clean press/release pairs, some chords, pops, stats, noise and restarts
    task automatic run_traffic(input int n);
        int                   stop_at;
        int                   pick;
        logic [KEY_IDX_W-1:0] k;
        logic [KEY_IDX_W-1:0] k2;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            pick = $urandom_range(0, 99);
            k = KEY_IDX_W'($urandom_range(0, NUM_KEYS - 1));
            if ($urandom_range(0, 19) == 0) begin
                tx_calm = !tx_calm;
                rx_calm = 1'($urandom_range(0, 1));
            end
            if (pick < 50) begin
                edge_item(k, 1'b0, tick);
                // contact bounce: a second falling edge
                if ($urandom_range(0, 3) == 0)
                    edge_item(k, 1'b0, tick + $urandom_range(0, 10));
                tick += press_span();
                edge_item(k, 1'b1, tick);
                tick += $urandom_range(0, cur_db + 20);
            end else if (pick < 60) begin
                // chord of two keys: both locked out
                k2 = k ^ KEY_IDX_W'($urandom_range(1, NUM_KEYS - 1));
                edge_item(k, 1'b0, tick);
                tick += $urandom_range(0, 20);
                edge_item(k2, 1'b0, tick);
                tick += press_span();
                edge_item(k, 1'b1, tick);
                edge_item(k2, 1'b1, tick + $urandom_range(0, 20));
                tick += cur_db + 1;
            end else if (pick < 76) begin
                pop_item();
            end else if (pick < 86) begin
                stats_item(k);
            end else if (pick < 96) begin
                edge_item(k, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? $urandom() : tick - $urandom_range(0, 100));
            end else begin
                if ($urandom_range(0, 1))
                    tick = $urandom();
                start_item(NUM_KEYS'($urandom_range(0, 15)), tick);
            end
        end
    endtask

    // Result side: random stalls per transaction, plus one long hold on request
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 5);
            if (rx_hold_req) begin
                gap = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [TICK_W-1:0]    t0;
        logic [KEY_IDX_W-1:0] k;
        int                   db;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing counts before start
        stats_item(2);
        pop_item();
        edge_item(1, 1'b0, 32'h10);
        edge_item(1, 1'b1, 32'h80);

        // start just below the tick wrap with keys 0 and 2 held
        t0 = 32'hFFFF_FFF0;
        start_item(4'b0101, t0);
        edge_item(0, 1'b1, t0 + 5);
        edge_item(1, 1'b0, t0 + 8);
        edge_item(1, 1'b0, t0 + 20);
        edge_item(1, 1'b1, t0 + 48);
        edge_item(3, 1'b0, 32'h30);
        edge_item(3, 1'b1, 32'h30 + 39);
        edge_item(2, 1'b1, 32'h100);
        // two keys down lock each other out
        edge_item(3, 1'b0, 32'h200);
        edge_item(0, 1'b0, 32'h205);
        edge_item(3, 1'b1, 32'h300);
        edge_item(0, 1'b1, 32'h300);
        edge_item(1, 1'b0, 32'h300);
        edge_item(1, 1'b1, 32'h358);
        // tick steps back: press long enough but too soon after the last accept
        edge_item(1, 1'b0, 32'h300);
        edge_item(1, 1'b1, 32'h360);
        repeat (3) pop_item();
        for (int i = 0; i < NUM_KEYS; i++)
            stats_item(KEY_IDX_W'(i));
        settle();

        // Zero debounce: every press qualifies, so the ring overflows
        program_debounce('0);
        tick = $urandom();
        start_item('0, tick);
        repeat (17) begin
            k = KEY_IDX_W'($urandom_range(0, NUM_KEYS - 1));
            edge_item(k, 1'b0, tick);
            edge_item(k, 1'b1, tick);
            tick += $urandom_range(0, 3);
        end
        stats_item(k);

        // long result stall while pops keep coming, filling the command queue
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        rx_hold_req = 1'b1;
        repeat (20) pop_item();
        settle();
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Largest debounce, starting close to the tick wrap
        program_debounce('1);
        tick = 32'hFFFF_0000 + $urandom_range(0, 255);
        start_item(NUM_KEYS'($urandom_range(0, 15)), tick);
        run_traffic(60);
        settle();

        // Random phases over a spread of debounce settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       db = 1;
                1:       db = $urandom_range(2, 300);
                2:       db = $urandom_range(301, 65534);
                3:       db = DEBOUNCE_RESET;
                default: db = $urandom_range(0, 300);
            endcase
            program_debounce(DEBOUNCE_W'(db));
            tick = $urandom();
            start_item(NUM_KEYS'($urandom_range(0, 15)), tick);
            run_traffic(70);
            settle();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
